/* sv/fpipt_pkg.sv */
// Shared types, constants and helper functions for the fixed-point executor
// with resident page table. No dependencies; imported by every module except fpipt_ram.
package fpipt_pkg;

    localparam int TABLE_SLOTS = 2048;
    localparam int SLOT_W      = $clog2(TABLE_SLOTS);
    localparam int CNT_W       = SLOT_W + 1;
    localparam int PAGE_W      = 27;
    localparam int TAG_W       = 3 * PAGE_W;
    localparam int SOFT_STEPS  = 16;
    localparam int DCNT_W      = $clog2(SOFT_STEPS + 1);

    localparam logic [7:0] OPC_SYNC = 8'h0F;
    localparam logic [7:0] OPC_RD   = 8'h10;
    localparam logic [7:0] OPC_WR   = 8'h11;
    localparam logic [7:0] OPC_MUL  = 8'h20;
    localparam logic [7:0] OPC_ADD  = 8'h21;
    localparam logic [7:0] OPC_SUB  = 8'h22;
    localparam logic [7:0] OPC_GRAD = 8'h30;
    localparam logic [7:0] OPC_LAT  = 8'h31;
    localparam logic [7:0] OPC_REP  = 8'h32;
    localparam logic [7:0] OPC_SOFT = 8'h40;
    localparam logic [7:0] OPC_DEC  = 8'h41;
    localparam logic [7:0] OPC_HASH = 8'h50;
    localparam logic [7:0] OPC_HALT = 8'hFF;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_SYNC = 2'd1;
    localparam logic [1:0] ST_HALT = 2'd2;
    localparam logic [1:0] ST_ILL  = 2'd3;

    localparam logic [1:0] EV_NONE  = 2'd0;
    localparam logic [1:0] EV_HIT   = 2'd1;
    localparam logic [1:0] EV_FILL  = 2'd2;
    localparam logic [1:0] EV_EVICT = 2'd3;

    localparam logic signed [31:0] CORE_POS   = 32'sd209715200;  // 3200.0 in Q16.16
    localparam logic signed [31:0] GRAD_K     = -32'sd8192;
    localparam logic signed [31:0] LAT_K      = -32'sd1024;
    localparam logic signed [31:0] DEC_K      = 32'sd32768;
    localparam logic signed [31:0] REPEL_BASE = 32'sd768;
    localparam logic signed [31:0] Q_MIN      = 32'sh8000_0000;
    localparam logic signed [31:0] Q_MAX      = 32'sh7FFF_FFFF;
    localparam logic [31:0]        Q_ONE      = 32'd65536;
    localparam logic [31:0]        AXIS_HI    = 32'd419430400;   // 6400.0 in Q16.16

    typedef enum logic [3:0] {
        OC_SYNC, OC_HALT, OC_RD, OC_WR, OC_MUL, OC_ADD, OC_SUB, OC_GRAD,
        OC_LAT, OC_REP, OC_SOFT, OC_DEC, OC_HASH, OC_ILL
    } t_op_cls;

    typedef enum logic [1:0] {FS_RS1, FS_RS2, FS_RS3, FS_RD} t_fsel;

    typedef struct packed {
        logic  accept;
        logic  fetch;
        t_fsel fsel;
        logic  exec;
        logic  mul;
        logic  post;
        logic  fin;
        logic  div_step;
        logic  div_fin;
        logic  rd_cap;
        logic  srch_step;
        logic  hit_take;
        logic  alloc;
        logic  retire;
    } t_ctl_cmd;

    typedef struct packed {
        t_op_cls cls;
        logic    div_done;
        logic    hit;
        logic    miss_done;
    } t_dp_stat;

    function automatic t_op_cls op_class(input logic [7:0] opc);
        t_op_cls c;
        unique case (opc)
            OPC_SYNC: c = OC_SYNC;
            OPC_HALT: c = OC_HALT;
            OPC_RD:   c = OC_RD;
            OPC_WR:   c = OC_WR;
            OPC_MUL:  c = OC_MUL;
            OPC_ADD:  c = OC_ADD;
            OPC_SUB:  c = OC_SUB;
            OPC_GRAD: c = OC_GRAD;
            OPC_LAT:  c = OC_LAT;
            OPC_REP:  c = OC_REP;
            OPC_SOFT: c = OC_SOFT;
            OPC_DEC:  c = OC_DEC;
            OPC_HASH: c = OC_HASH;
            default:  c = OC_ILL;
        endcase
        return c;
    endfunction

    function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
        logic signed [31:0] r;
        if (v[32] != v[31]) r = v[32] ? Q_MIN : Q_MAX;
        else                r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [31:0] sat48(input logic signed [47:0] v);
        logic signed [31:0] r;
        if ((&v[47:31]) || !(|v[47:31])) r = v[31:0];
        else                             r = v[47] ? Q_MIN : Q_MAX;
        return r;
    endfunction

    // Clamp to [0, 6400.0] and scale: floor(x * (P - 1) / (4 * P)) with P pages,
    // which is x/4 minus one when 4x exceeds (x mod 4) * AXIS_HI.
    function automatic logic [PAGE_W-1:0] to_page(input logic signed [31:0] q);
        logic [31:0] x;
        logic [33:0] lhs;
        logic [33:0] rhs;
        logic [29:0] qq;
        if (q[31])                    x = '0;
        else if ($unsigned(q) > AXIS_HI) x = AXIS_HI;
        else                          x = $unsigned(q);
        lhs = {x, 2'b00};
        rhs = 34'(x[1:0]) * 34'(AXIS_HI);
        qq  = x[31:2] - 30'(lhs > rhs);
        return qq[PAGE_W-1:0];
    endfunction

endpackage

/* sv/fpipt_ram.sv */
// Generic single-port RAM with registered read data.
// No dependencies; used for the page tag and page value stores.
module fpipt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

/* sv/fpipt_datapath.sv */
// Datapath: register file, multiplier, soft-sign divider, page search and
// output beat register. Depends on fpipt_pkg and fpipt_ram.
module fpipt_datapath
    import fpipt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  t_ctl_cmd    i_cmd,
    input  logic        i_in_cmd,
    input  logic [71:0] i_in_data,
    output t_dp_stat    o_stat,
    output logic [47:0] o_out_data
);
    logic                    r_parity;
    logic                    r_load;
    logic [31:0]             r_iw;
    logic [3:0]              r_lidx;
    logic signed [31:0]      r_rf [16];
    logic signed [31:0]      r_a, r_b, r_c, r_hd;
    logic signed [31:0]      r_m1, r_m2, r_mq, r_res;
    logic signed [63:0]      r_prod;
    logic [1:0]              r_event;
    logic [PAGE_W-1:0]       r_px, r_py, r_pz;
    logic [33:0]             r_rem;
    logic [32:0]             r_den;
    logic [SOFT_STEPS-1:0]   r_q;
    logic [DCNT_W-1:0]       r_dcnt;
    logic                    r_neg;
    logic                    r_inr;
    logic [CNT_W-1:0]        r_count;
    logic [SLOT_W-1:0]       r_cursor;
    logic [CNT_W-1:0]        r_sidx;
    logic                    r_cmp_v;
    logic [SLOT_W-1:0]       r_cmp_idx;
    logic [47:0]             r_out;

    t_op_cls                 cls;
    logic [3:0]              rd_f, rs1_f, rs2_f, rs3_f, faddr, didx;
    logic signed [31:0]      fdata, base, ax;
    logic [31:0]             mag;
    logic [33:0]             trial;
    logic                    full, written;
    logic [SLOT_W-1:0]       slot;
    logic                    tag_we, val_we;
    logic [SLOT_W-1:0]       tag_addr, val_addr;
    logic [TAG_W-1:0]        tag_rdata;
    logic [31:0]             val_wdata, val_rdata;
    logic [1:0]              status;

    assign cls   = op_class(r_iw[31:24]);
    assign rd_f  = r_iw[23:20];
    assign rs1_f = r_iw[19:16];
    assign rs2_f = r_iw[15:12];
    assign rs3_f = r_iw[11:8];

    always_comb begin
        case (i_cmd.fsel)
            FS_RS1:  faddr = rs1_f;
            FS_RS2:  faddr = rs2_f;
            FS_RS3:  faddr = rs3_f;
            default: faddr = rd_f;
        endcase
    end
    assign fdata = r_rf[faddr];

    assign base  = r_parity ? REPEL_BASE : -REPEL_BASE;
    assign ax    = (r_a == Q_MIN) ? Q_MAX : (r_a[31] ? -r_a : r_a);
    assign mag   = r_a[31] ? (~$unsigned(r_a) + 32'd1) : $unsigned(r_a);
    assign trial = {r_rem[32:0], 1'b0};
    assign full  = (r_count == CNT_W'(TABLE_SLOTS));
    assign slot  = full ? r_cursor : r_count[SLOT_W-1:0];

    // Page store port steering
    always_comb begin
        tag_we    = i_cmd.alloc;
        tag_addr  = i_cmd.alloc ? slot : r_sidx[SLOT_W-1:0];
        val_we    = 1'b0;
        val_addr  = r_a[SLOT_W-1:0];
        val_wdata = '0;
        if (i_cmd.alloc) begin
            val_we   = 1'b1;
            val_addr = slot;
        end else if (i_cmd.exec && cls == OC_WR) begin
            val_we    = ($unsigned(r_hd) < 32'(r_count));
            val_addr  = r_hd[SLOT_W-1:0];
            val_wdata = r_a;
        end
    end

    fpipt_ram #(.WIDTH(TAG_W), .DEPTH(TABLE_SLOTS)) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (tag_we),
        .i_addr  (tag_addr),
        .i_wdata ({r_px, r_py, r_pz}),
        .o_rdata (tag_rdata)
    );

    fpipt_ram #(.WIDTH(32), .DEPTH(TABLE_SLOTS)) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_addr  (val_addr),
        .i_wdata (val_wdata),
        .o_rdata (val_rdata)
    );

    always_comb begin
        written = 1'b1;
        status  = ST_DONE;
        if (!r_load) begin
            case (cls)
                OC_SYNC: begin status = ST_SYNC; written = 1'b0; end
                OC_HALT: begin status = ST_HALT; written = 1'b0; end
                OC_ILL:  begin status = ST_ILL;  written = 1'b0; end
                OC_WR:   written = 1'b0;
                default: written = 1'b1;
            endcase
        end
    end
    assign didx = r_load ? r_lidx : rd_f;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_parity <= 1'b0;
            r_count  <= '0;
            r_cursor <= '0;
            r_cmp_v  <= 1'b0;
            r_sidx   <= '0;
            r_dcnt   <= '0;
            for (int i = 0; i < 16; i++) r_rf[i] <= '0;
        end else begin
            if (i_cfg_we) r_parity <= i_cfg_wdata;

            if (i_cmd.accept) begin
                r_load  <= i_in_cmd;
                r_iw    <= i_in_data[31:0];
                r_lidx  <= i_in_data[35:32];
                r_res   <= i_in_data[67:36];
                r_event <= EV_NONE;
            end

            if (i_cmd.fetch) begin
                case (i_cmd.fsel)
                    FS_RS1:  r_a  <= fdata;
                    FS_RS2:  r_b  <= fdata;
                    FS_RS3:  r_c  <= fdata;
                    default: r_hd <= fdata;
                endcase
            end

            if (i_cmd.exec) begin
                case (cls)
                    OC_ADD: r_res <= sat33(33'(r_a) + 33'(r_b));
                    OC_SUB: r_res <= sat33(33'(r_a) - 33'(r_b));
                    OC_REP: r_res <= (r_a >= CORE_POS) ? base : -base;
                    OC_MUL: begin r_m1 <= r_a; r_m2 <= r_b; end
                    OC_GRAD: begin r_m1 <= GRAD_K; r_m2 <= r_a; end
                    OC_LAT: begin
                        r_m1 <= LAT_K;
                        r_m2 <= sat33(33'(r_a) - 33'(CORE_POS));
                    end
                    OC_DEC: begin r_m1 <= DEC_K; r_m2 <= r_a; end
                    OC_SOFT: begin
                        r_rem  <= 34'(mag);
                        r_den  <= 33'(Q_ONE) + 33'($unsigned(ax));
                        r_q    <= '0;
                        r_dcnt <= '0;
                        r_neg  <= r_a[31];
                    end
                    OC_RD: r_inr <= ($unsigned(r_a) < 32'(r_count));
                    OC_HASH: begin
                        r_px    <= to_page(r_a);
                        r_py    <= to_page(r_b);
                        r_pz    <= to_page(r_c);
                        r_sidx  <= '0;
                        r_cmp_v <= 1'b0;
                    end
                    default: ;
                endcase
            end

            if (i_cmd.mul)  r_prod <= r_m1 * r_m2;
            if (i_cmd.post) r_mq   <= sat48(r_prod[63:16]);
            if (i_cmd.fin)  r_res  <= (cls == OC_DEC) ? sat33(33'(r_a) + 33'(r_mq)) : r_mq;

            // One quotient bit per cycle; the remainder stays below the divisor
            if (i_cmd.div_step) begin
                if (trial >= {1'b0, r_den}) begin
                    r_rem <= trial - {1'b0, r_den};
                    r_q   <= {r_q[SOFT_STEPS-2:0], 1'b1};
                end else begin
                    r_rem <= trial;
                    r_q   <= {r_q[SOFT_STEPS-2:0], 1'b0};
                end
                r_dcnt <= r_dcnt + DCNT_W'(1);
            end
            if (i_cmd.div_fin) begin
                r_res <= r_neg ? -$signed(32'(r_q)) : $signed(32'(r_q));
            end

            if (i_cmd.rd_cap) r_res <= r_inr ? $signed(val_rdata) : '0;

            if (i_cmd.srch_step) begin
                if (r_sidx < r_count) begin
                    r_sidx    <= r_sidx + CNT_W'(1);
                    r_cmp_v   <= 1'b1;
                    r_cmp_idx <= r_sidx[SLOT_W-1:0];
                end else begin
                    r_cmp_v <= 1'b0;
                end
            end
            if (i_cmd.hit_take) begin
                r_res   <= $signed(32'(r_cmp_idx));
                r_event <= EV_HIT;
                r_cmp_v <= 1'b0;
            end
            if (i_cmd.alloc) begin
                r_res   <= $signed(32'(slot));
                r_event <= full ? EV_EVICT : EV_FILL;
                if (full) begin
                    r_cursor <= (r_cursor == SLOT_W'(TABLE_SLOTS - 1)) ? '0
                                                                       : r_cursor + SLOT_W'(1);
                end else begin
                    r_count <= r_count + CNT_W'(1);
                end
            end

            if (i_cmd.retire) begin
                if (written && didx != 4'd0) r_rf[didx] <= r_res;
                r_out <= {7'd0, r_event,
                          (written && didx != 4'd0) ? r_res : 32'sd0,
                          written ? didx : 4'd0, written, status};
            end
        end
    end

    assign o_stat.cls       = cls;
    assign o_stat.div_done  = (r_dcnt == DCNT_W'(SOFT_STEPS));
    assign o_stat.hit       = r_cmp_v && (tag_rdata == {r_px, r_py, r_pz});
    assign o_stat.miss_done = !r_cmp_v && (r_sidx >= r_count);
    assign o_out_data       = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_SLOTS))
        else $error("resident count beyond table size");
    a_cursor_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cursor != '0) |-> full)
        else $error("eviction cursor moved before table filled");
    a_alloc_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.alloc |-> (o_stat.miss_done && !o_stat.hit))
        else $error("slot allocated without a completed miss");
endmodule

/* sv/fpipt_ctrl.sv */
// Controller state machine: sequences operand fetch, execution, divider,
// page search and result hand-off. Depends on fpipt_pkg.
module fpipt_ctrl
    import fpipt_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_in_cmd,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output logic     o_in_ready,
    output logic     o_out_valid,
    output t_ctl_cmd o_cmd
);
    typedef enum logic [3:0] {
        S_IDLE, S_FA, S_FB, S_FC, S_FD, S_EXEC, S_MUL, S_POST, S_FIN,
        S_DIV, S_DFIN, S_RDC, S_SRCH, S_ALLOC, S_RET
    } t_state;

    t_state r_state, n_state;
    logic   r_ovalid;
    logic   out_free;

    assign out_free = !r_ovalid || i_out_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: if (i_in_valid) begin
                o_cmd.accept = 1'b1;
                n_state = i_in_cmd ? S_RET : S_FA;
            end
            S_FA: begin o_cmd.fetch = 1'b1; o_cmd.fsel = FS_RS1; n_state = S_FB; end
            S_FB: begin o_cmd.fetch = 1'b1; o_cmd.fsel = FS_RS2; n_state = S_FC; end
            S_FC: begin o_cmd.fetch = 1'b1; o_cmd.fsel = FS_RS3; n_state = S_FD; end
            S_FD: begin o_cmd.fetch = 1'b1; o_cmd.fsel = FS_RD;  n_state = S_EXEC; end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                case (i_stat.cls)
                    OC_MUL, OC_GRAD, OC_LAT, OC_DEC: n_state = S_MUL;
                    OC_SOFT: n_state = S_DIV;
                    OC_RD:   n_state = S_RDC;
                    OC_HASH: n_state = S_SRCH;
                    default: n_state = S_RET;
                endcase
            end
            S_MUL:  begin o_cmd.mul  = 1'b1; n_state = S_POST; end
            S_POST: begin o_cmd.post = 1'b1; n_state = S_FIN; end
            S_FIN:  begin o_cmd.fin  = 1'b1; n_state = S_RET; end
            S_DIV: begin
                if (i_stat.div_done) n_state = S_DFIN;
                else                 o_cmd.div_step = 1'b1;
            end
            S_DFIN: begin o_cmd.div_fin = 1'b1; n_state = S_RET; end
            S_RDC:  begin o_cmd.rd_cap  = 1'b1; n_state = S_RET; end
            S_SRCH: begin
                if (i_stat.hit) begin
                    o_cmd.hit_take = 1'b1;
                    n_state = S_RET;
                end else if (i_stat.miss_done) begin
                    n_state = S_ALLOC;
                end else begin
                    o_cmd.srch_step = 1'b1;
                end
            end
            S_ALLOC: begin o_cmd.alloc = 1'b1; n_state = S_RET; end
            S_RET: if (out_free) begin
                o_cmd.retire = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.retire)     r_ovalid <= 1'b1;
            else if (i_out_ready) r_ovalid <= 1'b0;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;
endmodule

/* sv/fixed_point_isa_exec_page_table_top.sv */
// Top level of the fixed-point instruction executor with page table.
// Depends on fpipt_pkg, fpipt_ctrl, fpipt_datapath (and fpipt_ram below it).
//
// Usage:
//   Input beats arrive on s_axis_*: tuser selects the kind of beat (0 executes
//   the instruction word in tdata, 1 loads load_value into register load_index).
//   Every input beat produces exactly one result beat on m_axis_*.
//   i_cfg_we/i_cfg_wdata write the agent parity bit (repel force sign); write it
//   only while the block is idle.
// Throughput:
//   One item at a time. Soft-sign produces 16 quotient bits from the restoring
//   divider, one per cycle. Page hashing walks the resident tag store one entry
//   per cycle through its single RAM port.
// Reset:
//   Synchronous, active low. Clears the register file, the resident count and
//   the eviction cursor. The page stores are not cleared; entries beyond the
//   resident count are never read.
// Stall:
//   The result sits in an output register; the next item is accepted while it
//   waits, but that item does not retire until the pending beat is taken.
module fixed_point_isa_exec_page_table_top
    import fpipt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,      // agent_parity
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: instruction_word[31:0], load_index[35:32], load_value[67:36], zero pad
    input  logic [71:0] s_axis_tdata,
    input  logic        s_axis_tuser,     // cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: status[1:0], dest_written[2], dest_index[6:3], dest_value[38:7],
    //        page_event[40:39], zero pad
    output logic [47:0] m_axis_tdata
);
    t_ctl_cmd cmd;
    t_dp_stat stat;

    // Sequencer: decides which datapath step runs each cycle
    fpipt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_cmd    (s_axis_tuser),
        .i_out_ready (m_axis_tready),
        .i_stat      (stat),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (cmd)
    );

    // Register file, arithmetic units, page stores and output beat register
    fpipt_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .i_in_cmd    (s_axis_tuser),
        .i_in_data   (s_axis_tdata),
        .o_stat      (stat),
        .o_out_data  (m_axis_tdata)
    );
endmodule

/* bench/fixed_point_isa_exec_page_table_top_tb.sv */
// Testbench for fixed_point_isa_exec_page_table_top: drives instruction and load
// beats, predicts every result beat with a local executor model and compares.
// Depends on fpipt_pkg and the top-level RTL only.
`timescale 1ns / 1ps

module fixed_point_isa_exec_page_table_top_tb;
    import fpipt_pkg::*;

    // Clock, reset and block ports
    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;

    fixed_point_isa_exec_page_table_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    localparam int QUIET_LIMIT = 40000;   // covers a full-table search plus stalls

    // One expected result beat
    typedef struct packed {
        logic [1:0]         status;
        logic               written;
        logic [3:0]         idx;
        logic signed [31:0] value;
        logic [1:0]         pevent;
    } t_exec_result;

    // Predictor state
    logic signed [31:0] regs_m [16];
    logic [PAGE_W-1:0]  tag_x [TABLE_SLOTS];
    logic [PAGE_W-1:0]  tag_y [TABLE_SLOTS];
    logic [PAGE_W-1:0]  tag_z [TABLE_SLOTS];
    logic signed [31:0] pval  [TABLE_SLOTS];
    int unsigned        resident;
    int unsigned        cursor;
    logic               parity_m;

    t_exec_result result_q[$];
    int  err_count;
    int  quiet_cycles;
    bit  idle_enable;
    bit  hold_sink;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ---------------- Arithmetic helpers ----------------

    function automatic logic signed [31:0] clip(input longint v);
        if (v > 64'sd2147483647) return Q_MAX;
        if (v < -64'sd2147483648) return Q_MIN;
        return v[31:0];
    endfunction

    // Q16.16 multiply, floor rounding (arithmetic shift floors)
    function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        longint p;
        p = longint'(a) * longint'(b);
        return clip(p >>> 16);
    endfunction

    function automatic logic signed [31:0] softsign(input logic signed [31:0] x);
        longint ax;
        ax = (x == Q_MIN) ? 64'sd2147483647 : (x < 0 ? -longint'(x) : longint'(x));
        return clip((longint'(x) * 65536) / (65536 + ax));   // truncates toward zero
    endfunction

    // Clamp to [0, 6400.0] and scale to a page number
    function automatic logic [PAGE_W-1:0] page_of(input logic signed [31:0] q);
        longint unsigned x;
        longint unsigned pages;
        pages = 64'd6400 * 64'd16384;
        x = (q < 0) ? 0 : longint'(q);
        if (x > AXIS_HI) x = AXIS_HI;
        return PAGE_W'((x * (pages - 1)) / AXIS_HI);
    endfunction

    // Execute one item against the predictor state
    function automatic t_exec_result execute(input logic cmd, input logic [31:0] w,
                                             input logic [3:0] li,
                                             input logic signed [31:0] lv);
        t_exec_result r;
        logic [7:0] opc;
        logic [3:0] d;
        logic signed [31:0] a, b, c, res;
        logic [PAGE_W-1:0] px, py, pz;
        int unsigned h, slot;
        bit found;
        r = '0;
        res = '0;
        if (cmd) begin
            r.written = 1'b1;
            r.idx = li;
            regs_m[li] = lv;
        end else begin
            opc = w[31:24];
            d = w[23:20];
            a = regs_m[w[19:16]];
            b = regs_m[w[15:12]];
            c = regs_m[w[11:8]];
            r.written = 1'b1;
            case (opc)
                OPC_SYNC: begin r.status = ST_SYNC; r.written = 1'b0; end
                OPC_HALT: begin r.status = ST_HALT; r.written = 1'b0; end
                OPC_RD: begin
                    h = a;
                    res = (h < resident) ? pval[h] : '0;
                end
                OPC_WR: begin
                    h = regs_m[d];
                    if (h < resident) pval[h] = a;
                    r.written = 1'b0;
                end
                OPC_MUL:  res = qmul(a, b);
                OPC_ADD:  res = clip(longint'(a) + longint'(b));
                OPC_SUB:  res = clip(longint'(a) - longint'(b));
                OPC_GRAD: res = qmul(GRAD_K, a);
                OPC_LAT:  res = qmul(LAT_K, clip(longint'(a) - longint'(CORE_POS)));
                OPC_REP: begin
                    res = (a >= CORE_POS) ? REPEL_BASE : -REPEL_BASE;
                    if (!parity_m) res = -res;
                end
                OPC_SOFT: res = softsign(a);
                OPC_DEC:  res = clip(longint'(a) + longint'(qmul(DEC_K, a)));
                OPC_HASH: begin
                    px = page_of(a);
                    py = page_of(b);
                    pz = page_of(c);
                    found = 0;
                    slot = 0;
                    for (int i = 0; i < resident; i++) begin
                        if (!found && tag_x[i] == px && tag_y[i] == py && tag_z[i] == pz) begin
                            found = 1;
                            slot = i;
                        end
                    end
                    if (found) r.pevent = EV_HIT;
                    else begin
                        if (resident < TABLE_SLOTS) begin
                            slot = resident;
                            resident++;
                            r.pevent = EV_FILL;
                        end else begin
                            slot = cursor;
                            cursor = (cursor + 1) % TABLE_SLOTS;
                            r.pevent = EV_EVICT;
                        end
                        tag_x[slot] = px;
                        tag_y[slot] = py;
                        tag_z[slot] = pz;
                        pval[slot] = '0;
                    end
                    res = slot;
                end
                default: begin r.status = ST_ILL; r.written = 1'b0; end
            endcase
            if (r.written) begin
                r.idx = d;
                regs_m[d] = res;
            end
        end
        regs_m[0] = '0;
        if (r.written) r.value = regs_m[r.idx];
        return r;
    endfunction

    // ---------------- Reporting and checking ----------------

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    // Check each result beat against the oldest prediction
    always @(posedge i_clk) begin
        t_exec_result exp_r;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (result_q.size() == 0) begin
                report_mismatch("unexpected beat", m_axis_tdata[31:0], 0);
            end else begin
                exp_r = result_q.pop_front();
                if (m_axis_tdata[1:0] != exp_r.status)
                    report_mismatch("status", m_axis_tdata[1:0], exp_r.status);
                if (m_axis_tdata[2] != exp_r.written)
                    report_mismatch("dest_written", m_axis_tdata[2], exp_r.written);
                if (m_axis_tdata[6:3] != exp_r.idx)
                    report_mismatch("dest_index", m_axis_tdata[6:3], exp_r.idx);
                if (m_axis_tdata[38:7] != exp_r.value)
                    report_mismatch("dest_value", m_axis_tdata[38:7], exp_r.value);
                if (m_axis_tdata[40:39] != exp_r.pevent)
                    report_mismatch("page_event", m_axis_tdata[40:39], exp_r.pevent);
            end
        end
    end

    // Receiver stalls: random bursts with tready low while idling is enabled, then a random run high
    initial begin
        m_axis_tready = 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (idle_enable && ($urandom_range(0, 3) == 0)) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > QUIET_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // ---------------- Stimulus ----------------

    // Send one beat; predict at acceptance. Sender gap bursts come before the beat;
    // tvalid stays high into the next call, so it drops only on a gap or a drain.
    task automatic send_item(input logic cmd, input logic [31:0] w,
                             input logic [3:0] li, input logic signed [31:0] lv);
        if (idle_enable && ($urandom_range(0, 3) == 0)) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {4'h0, lv, li, w};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        result_q.push_back(execute(cmd, w, li, lv));
    endtask

    task automatic load_reg(input logic [3:0] r, input logic signed [31:0] v);
        send_item(1'b1, $urandom, r, v);
    endtask

    function automatic logic [31:0] instr(input logic [7:0] opc, input logic [3:0] d,
                                          input logic [3:0] s1, input logic [3:0] s2,
                                          input logic [3:0] s3);
        return {opc, d, s1, s2, s3, 8'($urandom)};
    endfunction

    task automatic run_op(input logic [7:0] opc, input logic [3:0] d,
                          input logic [3:0] s1, input logic [3:0] s2,
                          input logic [3:0] s3);
        send_item(1'b0, instr(opc, d, s1, s2, s3), 4'($urandom), $urandom);
    endtask

    // Drop tvalid, drain the result stream, then give the block time to settle
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (result_q.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic write_parity(input logic p);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= p;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        parity_m = p;
    endtask

    function automatic logic signed [31:0] edge_value();
        case ($urandom_range(0, 9))
            0: return Q_MIN;
            1: return Q_MAX;
            2: return 0;
            3: return CORE_POS;
            4: return CORE_POS - 1;
            5: return AXIS_HI;
            6: return -1;
            7: return 32'($urandom_range(0, 65536 * 8));
            default: return $urandom;
        endcase
    endfunction

    // Arithmetic extremes, every arithmetic operation, R0 writes, halt/sync/illegal
    task automatic test_directed_ops();
        load_reg(1, Q_MAX);
        load_reg(2, Q_MIN);
        load_reg(3, CORE_POS);
        load_reg(0, 32'sd12345);            // load to R0 still reads back zero
        run_op(OPC_ADD, 4, 1, 1, 0);        // saturate high
        run_op(OPC_SUB, 5, 2, 1, 0);        // saturate low
        run_op(OPC_MUL, 6, 2, 2, 0);
        run_op(OPC_MUL, 0, 1, 1, 0);        // write to R0
        run_op(OPC_GRAD, 7, 2, 0, 0);
        run_op(OPC_LAT, 8, 2, 0, 0);
        run_op(OPC_REP, 9, 3, 0, 0);
        run_op(OPC_REP, 9, 0, 0, 0);
        run_op(OPC_SOFT, 10, 2, 0, 0);      // |min| taken as max
        run_op(OPC_SOFT, 10, 1, 0, 0);
        run_op(OPC_DEC, 11, 1, 0, 0);
        run_op(OPC_DEC, 11, 2, 0, 0);
        run_op(OPC_SYNC, 1, 1, 1, 1);
        run_op(OPC_HALT, 1, 1, 1, 1);
        run_op(8'h00, 1, 1, 1, 1);          // unknown opcode
        run_op(8'hFE, 1, 1, 1, 1);
        run_op(OPC_RD, 12, 0, 0, 0);        // read with empty table gives 0
    endtask

    // Fill, hit, read/write with in- and out-of-range handles
    task automatic test_page_table();
        load_reg(1, -32'sd5);                // clamps to page 0
        load_reg(2, Q_MAX);                  // clamps to top page
        load_reg(3, 32'sd65536);
        run_op(OPC_HASH, 4, 1, 2, 3);        // fill slot 0
        run_op(OPC_HASH, 5, 1, 2, 3);        // hit slot 0
        run_op(OPC_HASH, 6, 2, 1, 3);        // fill slot 1
        load_reg(7, 32'sd777);
        run_op(OPC_WR, 6, 7, 0, 0);          // page_value[1] <- 777
        run_op(OPC_RD, 8, 6, 0, 0);
        load_reg(9, 32'sd50);                // out of range
        run_op(OPC_WR, 9, 7, 0, 0);
        run_op(OPC_RD, 8, 9, 0, 0);
        load_reg(9, -32'sd1);
        run_op(OPC_RD, 8, 9, 0, 0);
    endtask

    // Mostly well-formed register/page traffic with random content
    task automatic test_random_mix(input int count);
        logic [7:0] opc;
        logic [7:0] opcs [13];
        opcs = '{OPC_SYNC, OPC_RD, OPC_WR, OPC_MUL, OPC_ADD, OPC_SUB, OPC_GRAD,
                 OPC_LAT, OPC_REP, OPC_SOFT, OPC_DEC, OPC_HASH, OPC_HALT};
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(0, 9))
                0, 1: send_item(1'b1, $urandom, 4'($urandom), edge_value());
                2: begin
                    // small coordinates give frequent page hits
                    load_reg(4'($urandom_range(1, 15)), 32'($urandom_range(0, 3)) <<< 18);
                end
                3: send_item(1'b0, $urandom, 4'($urandom), $urandom);     // noise
                default: begin
                    opc = opcs[$urandom_range(0, 12)];
                    send_item(1'b0, {opc, 24'($urandom)}, 4'($urandom), $urandom);
                end
            endcase
        end
    endtask

    // Hash a run of distinct pages back to back, then revisit and touch the newest
    task automatic test_page_fill();
        for (int n = 0; n < 30; n++) begin
            load_reg(1, 32'(n) <<< 4);
            run_op(OPC_HASH, 2, 1, 0, 0);
        end
        run_op(OPC_HASH, 2, 1, 0, 0);       // hit
        run_op(OPC_WR, 2, 1, 0, 0);
        run_op(OPC_RD, 4, 2, 0, 0);
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        err_count     = 0;
        quiet_cycles  = 0;
        idle_enable   = 1'b1;
        for (int i = 0; i < 16; i++) regs_m[i] = '0;
        resident = 0;
        cursor   = 0;
        parity_m = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_parity(1'b1);
        test_directed_ops();
        wait_idle();
        write_parity(1'b0);
        run_op(OPC_REP, 9, 3, 0, 0);
        run_op(OPC_REP, 9, 0, 0, 0);
        test_page_table();
        test_random_mix(100);
        wait_idle();
        write_parity(1'b1);
        test_random_mix(60);
        // final stretch: no idling on either side
        idle_enable = 1'b0;
        test_page_fill();
        test_random_mix(20);

        wait_idle();
        if (err_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
